[design/crsm_pkg.sv]
// types and constants shared by the slot manager files
// no dependencies
package crsm_pkg;

  localparam int unsigned OpW        = 3;
  localparam int unsigned RowW       = 31;
  localparam int unsigned SlotFieldW = 10;
  localparam int unsigned CapW       = 11;
  localparam int unsigned CapReset   = 1024;

  typedef enum logic [OpW-1:0] {
    OP_INSERT      = 3'd0,
    OP_REFERENCE   = 3'd1,
    OP_FIND_VICTIM = 3'd2,
    OP_EVICT       = 3'd3,
    OP_QUERY       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_VICTIM = 2'd2,
    ST_BAD_SLOT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_INS_POP,
    S_INS_WR,
    S_LOOK,
    S_WALK_RD,
    S_WALK_EV
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]        opcode;
    logic [RowW-1:0]       row_id;
    logic [SlotFieldW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [SlotFieldW-1:0] result_slot;
    logic [RowW-1:0]       result_row_id;
    logic                  tag_match;
    status_e               status;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic tag_we;
    logic valid_we;
    logic valid_wd;
    logic stale_we;
    logic stale_wd;
  } mem_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

[design/crsm_free_fifo.sv]
// queue of freed slot numbers, one memory with head, tail and count
// depends on crsm_pkg
module crsm_free_fifo #(
  parameter int unsigned Depth = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [$clog2(Depth)-1:0]   push_data_i,
  input  logic                       pop_i,
  output logic [$clog2(Depth)-1:0]   pop_data_o,
  output crsm_pkg::fifo_stat_t       stat_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [IdxW-1:0] mem [Depth];
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] rd_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign pop_data_o   = rd_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop_i) begin
      head_d  = (head_q == IdxW'(Depth - 1)) ? '0 : head_q + IdxW'(1);
      count_d = count_q - CntW'(1);
    end else if (push_i) begin
      tail_d  = (tail_q == IdxW'(Depth - 1)) ? '0 : tail_q + IdxW'(1);
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= push_data_i;
    end
    if (pop_i) begin
      rd_q <= mem[head_q];
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty free queue");

  a_push_nonfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full && !pop_i)) else $error("bad push to free queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("free queue count out of range");

endmodule

[design/crsm_slot_store.sv]
// per-slot tag, valid and stale memories, one address, registered reads
// depends on crsm_pkg
module crsm_slot_store #(
  parameter int unsigned Depth = 1024
) (
  input  logic                          clk_i,
  input  crsm_pkg::mem_ctl_t            ctl_i,
  input  logic [$clog2(Depth)-1:0]      addr_i,
  input  logic [crsm_pkg::RowW-1:0]     tag_i,
  output logic                          valid_o,
  output logic                          stale_o,
  output logic [crsm_pkg::RowW-1:0]     tag_o
);

  logic [crsm_pkg::RowW-1:0] tag_mem   [Depth];
  logic                      valid_mem [Depth];
  logic                      stale_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.tag_we) begin
      tag_mem[addr_i] <= tag_i;
    end
    if (ctl_i.valid_we) begin
      valid_mem[addr_i] <= ctl_i.valid_wd;
    end
    if (ctl_i.stale_we) begin
      stale_mem[addr_i] <= ctl_i.stale_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      tag_o   <= tag_mem[addr_i];
      valid_o <= valid_mem[addr_i];
      stale_o <= stale_mem[addr_i];
    end
  end

endmodule

[design/clock_replacement_slot_manager.sv]
// slot table with clock replacement: sequencer, hands and result register
// depends on crsm_pkg, crsm_free_fifo, crsm_slot_store
//
//   channel   handshake               payload
//   command   start / busy            cmd_i    (opcode, row_id, slot)
//   result    done_o strobe           result_o (slot, row id, match, status)
//   config    cfg_valid_i/cfg_ready_o cfg_data_i (capacity)
//
// find victim visits at most 2 x capacity slots, with one memory read and one stale
// write per slot on the single port; insert takes its slot from the free queue
// if it is not empty, else from the insert hand
// after reset a clearing pass over all MAX_SLOTS slots holds busy high
// the done_o strobe is high for one cycle only; the receiver cannot stall it
module clock_replacement_slot_manager #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  crsm_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output crsm_pkg::res_t                result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [crsm_pkg::CapW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(MAX_SLOTS);
  localparam int unsigned CntW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned StepW = CntW + 1;
  localparam int unsigned WideW = (CntW > crsm_pkg::CapW) ? CntW : crsm_pkg::CapW;

  crsm_pkg::state_e state_q, state_d;
  crsm_pkg::cmd_t   cmd_q, cmd_d;
  crsm_pkg::res_t   res_q, res_d;
  logic             done_q, done_d;
  logic [crsm_pkg::CapW-1:0] cap_cfg_q;
  logic [IdxW-1:0]  hand_q, hand_d;
  logic [CntW-1:0]  ins_hand_q, ins_hand_d;
  logic [StepW-1:0] step_q, step_d;
  logic [IdxW-1:0]  clr_q, clr_d;
  logic [IdxW-1:0]  slot_q, slot_d;

  crsm_pkg::mem_ctl_t   mem_ctl;
  logic [IdxW-1:0]      mem_addr;
  logic                 valid_rd, stale_rd;
  logic [crsm_pkg::RowW-1:0] tag_rd;
  logic                 fifo_push, fifo_pop;
  logic [IdxW-1:0]      fifo_rdata;
  crsm_pkg::fifo_stat_t fifo_stat;

  logic [WideW-1:0] cap_wide;
  logic [CntW-1:0]  cap_live;
  crsm_pkg::op_e    op;
  logic             in_range;
  logic [IdxW-1:0]  idx;
  logic             ins_avail;
  logic [IdxW-1:0]  hand_start;
  logic [CntW-1:0]  hand_inc;
  logic [IdxW-1:0]  hand_next;
  logic [StepW-1:0] step_inc;
  logic             walk_hit, walk_last;
  logic             accept;

  // capacity of zero acts as one, above the table size as the table size
  assign cap_wide  = WideW'(cap_cfg_q);
  assign cap_live  = (cap_wide == '0) ? CntW'(1) :
                     (cap_wide > WideW'(MAX_SLOTS)) ? CntW'(MAX_SLOTS) : CntW'(cap_cfg_q);
  assign op        = crsm_pkg::op_e'(cmd_q.opcode);
  assign in_range  = WideW'(cmd_q.slot) < WideW'(cap_live);
  assign idx       = IdxW'(cmd_q.slot);
  assign ins_avail = ins_hand_q < cap_live;
  assign hand_start = (CntW'(hand_q) >= cap_live) ? '0 : hand_q;
  assign hand_inc  = CntW'(hand_q) + CntW'(1);
  assign hand_next = (hand_inc >= cap_live) ? '0 : IdxW'(hand_inc);
  assign step_inc  = step_q + StepW'(1);
  // after two rounds every slot is stale, so later rounds cannot change the outcome
  assign walk_hit  = stale_rd && valid_rd;
  assign walk_last = (step_inc == {cap_live, 1'b0});

  assign busy        = (state_q != crsm_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crsm_pkg::S_CLEAR: begin
        if (clr_q == IdxW'(MAX_SLOTS - 1)) state_d = crsm_pkg::S_IDLE;
      end
      crsm_pkg::S_IDLE: begin
        if (start) state_d = crsm_pkg::S_DECODE;
      end
      crsm_pkg::S_DECODE: begin
        unique case (op)
          crsm_pkg::OP_INSERT: begin
            if (!fifo_stat.empty) state_d = crsm_pkg::S_INS_POP;
            else if (ins_avail)   state_d = crsm_pkg::S_INS_WR;
            else                  state_d = crsm_pkg::S_IDLE;
          end
          crsm_pkg::OP_FIND_VICTIM: state_d = crsm_pkg::S_WALK_RD;
          crsm_pkg::OP_EVICT,
          crsm_pkg::OP_QUERY: begin
            state_d = in_range ? crsm_pkg::S_LOOK : crsm_pkg::S_IDLE;
          end
          default: state_d = crsm_pkg::S_IDLE;
        endcase
      end
      crsm_pkg::S_INS_POP: state_d = crsm_pkg::S_INS_WR;
      crsm_pkg::S_INS_WR:  state_d = crsm_pkg::S_IDLE;
      crsm_pkg::S_LOOK:    state_d = crsm_pkg::S_IDLE;
      crsm_pkg::S_WALK_RD: state_d = crsm_pkg::S_WALK_EV;
      crsm_pkg::S_WALK_EV: begin
        state_d = (walk_hit || walk_last) ? crsm_pkg::S_IDLE : crsm_pkg::S_WALK_RD;
      end
      default: state_d = crsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d      = cmd_q;
    res_d      = res_q;
    done_d     = 1'b0;
    hand_d     = hand_q;
    ins_hand_d = ins_hand_q;
    step_d     = step_q;
    clr_d      = clr_q;
    slot_d     = slot_q;
    mem_ctl    = '0;
    mem_addr   = hand_q;
    fifo_push  = 1'b0;
    fifo_pop   = 1'b0;
    unique case (state_q)
      crsm_pkg::S_CLEAR: begin
        mem_addr         = clr_q;
        mem_ctl.valid_we = 1'b1;
        mem_ctl.valid_wd = 1'b0;
        mem_ctl.stale_we = 1'b1;
        mem_ctl.stale_wd = 1'b1;
        clr_d            = clr_q + IdxW'(1);
      end
      crsm_pkg::S_IDLE: begin
        if (accept) cmd_d = cmd_i;
      end
      crsm_pkg::S_DECODE: begin
        unique case (op)
          crsm_pkg::OP_INSERT: begin
            if (!fifo_stat.empty) begin
              fifo_pop = 1'b1;
            end else if (ins_avail) begin
              slot_d     = IdxW'(ins_hand_q);
              ins_hand_d = ins_hand_q + CntW'(1);
            end else begin
              res_d        = '0;
              res_d.status = crsm_pkg::ST_FULL;
              done_d       = 1'b1;
            end
          end
          crsm_pkg::OP_REFERENCE: begin
            res_d  = '0;
            done_d = 1'b1;
            if (in_range) begin
              mem_addr         = idx;
              mem_ctl.stale_we = 1'b1;
              mem_ctl.stale_wd = 1'b0;
            end else begin
              res_d.status = crsm_pkg::ST_BAD_SLOT;
            end
          end
          crsm_pkg::OP_FIND_VICTIM: begin
            hand_d = hand_start;
            step_d = '0;
          end
          crsm_pkg::OP_EVICT,
          crsm_pkg::OP_QUERY: begin
            if (in_range) begin
              mem_addr      = idx;
              mem_ctl.rd_en = 1'b1;
            end else begin
              res_d        = '0;
              res_d.status = crsm_pkg::ST_BAD_SLOT;
              done_d       = 1'b1;
            end
          end
          default: begin
            res_d  = '0;
            done_d = 1'b1;
          end
        endcase
      end
      crsm_pkg::S_INS_POP: begin
        slot_d = fifo_rdata;
      end
      crsm_pkg::S_INS_WR: begin
        mem_addr          = slot_q;
        mem_ctl.tag_we    = 1'b1;
        mem_ctl.valid_we  = 1'b1;
        mem_ctl.valid_wd  = 1'b1;
        mem_ctl.stale_we  = 1'b1;
        mem_ctl.stale_wd  = 1'b0;
        res_d             = '0;
        res_d.result_slot = crsm_pkg::SlotFieldW'(slot_q);
        done_d            = 1'b1;
      end
      crsm_pkg::S_LOOK: begin
        res_d    = '0;
        done_d   = 1'b1;
        mem_addr = idx;
        if (op == crsm_pkg::OP_EVICT) begin
          if (!valid_rd) begin
            res_d.status = crsm_pkg::ST_BAD_SLOT;
          end else begin
            mem_ctl.valid_we = 1'b1;
            mem_ctl.valid_wd = 1'b0;
            fifo_push        = !fifo_stat.full;
          end
        end else begin
          res_d.tag_match = valid_rd && (tag_rd == cmd_q.row_id);
        end
      end
      crsm_pkg::S_WALK_RD: begin
        mem_addr      = hand_q;
        mem_ctl.rd_en = 1'b1;
      end
      crsm_pkg::S_WALK_EV: begin
        mem_addr         = hand_q;
        mem_ctl.stale_we = 1'b1;
        mem_ctl.stale_wd = 1'b1;
        hand_d           = hand_next;
        step_d           = step_inc;
        if (walk_hit) begin
          res_d               = '0;
          res_d.result_slot   = crsm_pkg::SlotFieldW'(hand_q);
          res_d.result_row_id = tag_rd;
          done_d              = 1'b1;
        end else if (walk_last) begin
          res_d        = '0;
          res_d.status = crsm_pkg::ST_NO_VICTIM;
          done_d       = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= crsm_pkg::S_CLEAR;
      done_q     <= 1'b0;
      cap_cfg_q  <= crsm_pkg::CapW'(crsm_pkg::CapReset);
      hand_q     <= '0;
      ins_hand_q <= '0;
      step_q     <= '0;
      clr_q      <= '0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      hand_q     <= hand_d;
      ins_hand_q <= ins_hand_d;
      step_q     <= step_d;
      clr_q      <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    slot_q <= slot_d;
  end

  crsm_slot_store #(
    .Depth (MAX_SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .tag_i   (cmd_q.row_id),
    .valid_o (valid_rd),
    .stale_o (stale_rd),
    .tag_o   (tag_rd)
  );

  crsm_free_fifo #(
    .Depth (MAX_SLOTS)
  ) u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (idx),
    .pop_i       (fifo_pop),
    .pop_data_o  (fifo_rdata),
    .stat_o      (fifo_stat)
  );

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !done_o) else $error("result strobe right after accept");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != crsm_pkg::ST_OK)) |->
      ((result_o.result_row_id == '0) && !result_o.tag_match))
    else $error("error result carries data");

endmodule
